@@ rtl/rkrl_pkg.sv @@
// ----------------------------------------------------------------------------
// rkrl_pkg
// Shared constants and controller/datapath interface types for the
// recent key repeat limiter.
// ----------------------------------------------------------------------------
package rkrl_pkg;

  localparam int unsigned WindowDepthDef = 128;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CountW  = 8;

  localparam logic [CfgW-1:0] WindowSizeRst = 8'd100;
  localparam logic [CfgW-1:0] DupLimitRst   = 8'd30;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegWindowSize = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDupLimit   = 8'd1;

  // item kinds
  localparam logic KindCheck  = 1'b0;
  localparam logic KindRecord = 1'b1;

  typedef struct packed {
    logic take_item;
    logic rd_issue;
    logic out_load;
  } rkrl_cmd_t;

  typedef struct packed {
    logic win_empty;
    logic scan_last;
    logic out_free;
  } rkrl_sts_t;

endpackage

@@ rtl/rkrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// rkrl_ctrl
// Sequencer: takes a word, runs the history scan for a check and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module rkrl_ctrl import rkrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_ready_o,
  input  rkrl_sts_t sts_i,
  output rkrl_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.take_item = 1'b0;
    cmd_o.rd_issue  = 1'b0;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          if (in_kind_i == KindRecord || sts_i.win_empty) begin
            state_d = StFinish;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      // last read word is compared here
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rkrl_dp.sv @@
// ----------------------------------------------------------------------------
// rkrl_dp
// Datapath: configuration registers, history ring memory, ring pointers,
// match counter and output register.
// ----------------------------------------------------------------------------
module rkrl_dp import rkrl_pkg::*; #(
  parameter int unsigned WindowDepth = WindowDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_kind_i,
  input  logic [KeyW-1:0]    in_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_discard_o,
  output logic [CountW-1:0]  out_match_count_o,
  input  rkrl_cmd_t          cmd_i,
  output rkrl_sts_t          sts_o
);

  localparam int unsigned SlotW = $clog2(WindowDepth);
  localparam int unsigned OccW  = $clog2(WindowDepth + 1);
  localparam int unsigned CmpW  = (OccW > CfgW) ? OccW : CfgW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WindowDepth - 1);
  localparam logic [CmpW-1:0]  DepthCmp = CmpW'(WindowDepth);
  localparam logic [CmpW-1:0]  CountMax = CmpW'({CountW{1'b1}});

  logic [CfgW-1:0]   win_size_q, dup_limit_q;
  logic [OccW-1:0]   occ_q;
  logic [SlotW-1:0]  wr_slot_q;
  logic [SlotW-1:0]  rd_ptr_q;
  logic [OccW-1:0]   remain_q;
  logic [KeyW-1:0]   key_q;
  logic [KeyW-1:0]   rd_data_q;
  logic              rd_vld_q;
  logic [OccW-1:0]   count_q;
  logic              out_valid_q;
  logic              out_discard_q;
  logic [CountW-1:0] out_count_q;

  logic [KeyW-1:0]   hist_mem [WindowDepth];

  logic [CmpW-1:0]   eff_size;
  logic [CmpW-1:0]   ws_ext;
  logic [CmpW-1:0]   cnt_ext;
  logic              occ_below;
  logic              rec_take;
  logic              chk_take;
  logic [SlotW-1:0]  wr_slot_inc;
  logic [SlotW-1:0]  wr_slot_dec;
  logic [SlotW-1:0]  rd_ptr_dec;

  assign ws_ext  = CmpW'(win_size_q);
  assign cnt_ext = CmpW'(count_q);

  always_comb begin
    if (win_size_q == '0) begin
      eff_size = CmpW'(1);
    end else if (ws_ext > DepthCmp) begin
      eff_size = DepthCmp;
    end else begin
      eff_size = ws_ext;
    end
  end

  assign occ_below   = CmpW'(occ_q) < eff_size;
  assign rec_take    = cmd_i.take_item && (in_kind_i == KindRecord);
  assign chk_take    = cmd_i.take_item && (in_kind_i == KindCheck);
  assign wr_slot_inc = (wr_slot_q == LastSlot) ? '0 : wr_slot_q + 1'b1;
  assign wr_slot_dec = (wr_slot_q == '0) ? LastSlot : wr_slot_q - 1'b1;
  assign rd_ptr_dec  = (rd_ptr_q == '0) ? LastSlot : rd_ptr_q - 1'b1;

  assign sts_o.win_empty = (occ_q == '0);
  assign sts_o.scan_last = (remain_q == OccW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= WindowSizeRst;
      dup_limit_q <= DupLimitRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegWindowSize) begin
        win_size_q <= cfg_data_i;
      end else if (cfg_index_i == RegDupLimit) begin
        dup_limit_q <= cfg_data_i;
      end
    end
  end

  // history ring
  always_ff @(posedge clk_i) begin
    if (rec_take) begin
      hist_mem[wr_slot_q] <= in_key_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= hist_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      wr_slot_q <= '0;
    end else if (rec_take) begin
      wr_slot_q <= wr_slot_inc;
      if (occ_below) begin
        occ_q <= occ_q + 1'b1;
      end
    end
  end

  // scan walks back from the newest word, the count never passes occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      remain_q <= '0;
      rd_vld_q <= 1'b0;
      count_q  <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      if (chk_take) begin
        rd_ptr_q <= wr_slot_dec;
        remain_q <= occ_q;
      end else if (cmd_i.rd_issue) begin
        rd_ptr_q <= rd_ptr_dec;
        remain_q <= remain_q - 1'b1;
      end
      if (cmd_i.take_item) begin
        count_q <= '0;
      end else if (rd_vld_q && (rd_data_q == key_q)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_take) begin
      key_q <= in_key_i;
    end
  end

  // output register, count is zero for a record word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // discard uses the full count, the reported count saturates
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_discard_q <= (win_size_q > dup_limit_q) && (cnt_ext > CmpW'(dup_limit_q));
      out_count_q   <= (cnt_ext > CountMax) ? '1 : CountW'(cnt_ext);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_discard_o     = out_discard_q;
  assign out_match_count_o = out_count_q;

endmodule

@@ rtl/recent_key_repeat_limiter.sv @@
// ----------------------------------------------------------------------------
// recent_key_repeat_limiter
// Sliding window repeat limiter over recently recorded 32-bit keys.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries a kind and a key. A record
// word appends the key to the history ring; a check word counts the ring
// entries equal to its key and flags discard when the count is above
// dup_limit while window_size is above dup_limit. Every input word gives
// exactly one output word on out_valid_o/out_ready_i.
// A record goes straight to the finish state, where its result is loaded
// into the output register once that is free. A check first runs a scan
// state that reads one history word per cycle from the single-port ring
// memory, newest first, one word per occupied entry, then a drain state
// for the last compare, then finish; a check on an empty window skips both.
// One word is in flight at a time.
// The output register holds a finished word, so a new input word is taken
// while it waits; a word that finishes before the receiver drains the
// register waits in place and holds off further input.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken; index 0
// is window_size, index 1 dup_limit, other indexes are ignored.
// Reset empties the window and loads window_size 100 and dup_limit 30.
// ----------------------------------------------------------------------------
module recent_key_repeat_limiter import rkrl_pkg::*; #(
  parameter int unsigned WindowDepth = WindowDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_kind_i,
  input  logic [KeyW-1:0]    in_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_discard_o,
  output logic [CountW-1:0]  out_match_count_o
);

  rkrl_cmd_t cmd;
  rkrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rkrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rkrl_dp #(
    .WindowDepth (WindowDepth)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_kind_i         (in_kind_i),
    .in_key_i          (in_key_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_discard_o     (out_discard_o),
    .out_match_count_o (out_match_count_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

@@ bench/rkrl_checker.sv @@
// ----------------------------------------------------------------------------
// rkrl_checker
// Watches the configuration, input and output channels of the repeat
// limiter. It keeps its own history ring and register copies, works out
// the result of every accepted input word and compares each output word,
// field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module rkrl_checker import rkrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               word_valid_i,
  input  logic               word_ready_i,
  input  logic               word_kind_i,
  input  logic [KeyW-1:0]    word_key_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic               res_discard_i,
  input  logic [CountW-1:0]  res_count_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        words_o,
  output int unsigned        checks_o,
  output int unsigned        discards_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OwedDepth = 8;

  typedef struct packed {
    logic              discard;
    logic [CountW-1:0] count;
  } verdict_t;

  logic [KeyW-1:0] ring_q [WindowDepthDef];
  int unsigned     fill;
  int unsigned     slot;
  logic [CfgW-1:0] win_size;
  logic [CfgW-1:0] dup_lim;
  verdict_t        owed_q [OwedDepth];
  int unsigned     owed_rd;
  int unsigned     owed_wr;
  int unsigned     owed_n;
  int unsigned     bad;
  int unsigned     words;
  int unsigned     checks;
  int unsigned     discards;

  // updates the ring on a record, counts matches on a check
  function automatic verdict_t repeat_verdict(logic kind, logic [KeyW-1:0] key);
    verdict_t    v;
    int unsigned span;
    int unsigned pos;
    int unsigned hits;
    v = '0;
    if (kind == KindRecord) begin
      ring_q[slot] = key;
      slot = (slot + 1) % WindowDepthDef;
      span = (win_size == '0) ? 1 : int'(win_size);
      if (span > WindowDepthDef) span = WindowDepthDef;
      // a shrunk window keeps its fill, each record swaps one entry
      if (fill < span) fill++;
    end else begin
      hits = 0;
      pos = slot;
      for (int i = 0; i < fill; i++) begin
        pos = (pos == 0) ? WindowDepthDef - 1 : pos - 1;
        if (ring_q[pos] == key) hits++;
      end
      // raw register values decide whether discard is possible at all
      v.discard = (win_size > dup_lim) && (hits > dup_lim);
      v.count = (hits > 255) ? CountW'(255) : CountW'(hits);
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      win_size = WindowSizeRst;
      dup_lim = DupLimitRst;
      fill = 0;
      slot = 0;
      owed_rd = 0;
      owed_wr = 0;
      owed_n = 0;
      bad = 0;
      words = 0;
      checks = 0;
      discards = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegWindowSize: win_size = cfg_data_i;
          RegDupLimit:   dup_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (owed_n == 0) begin
          $error("result word with none owed: discard %0d match_count %0d",
                 res_discard_i, res_count_i);
          bad++;
        end else begin
          want = owed_q[owed_rd];
          owed_rd = (owed_rd + 1) % OwedDepth;
          owed_n--;
          if (res_discard_i !== want.discard) begin
            $error("discard: expected %0d, actual %0d", want.discard, res_discard_i);
            bad++;
          end
          if (res_count_i !== want.count) begin
            $error("match_count: expected %0d, actual %0d", want.count, res_count_i);
            bad++;
          end
        end
      end
      if (word_valid_i && word_ready_i) begin
        want = repeat_verdict(word_kind_i, word_key_i);
        if (owed_n == OwedDepth) begin
          $error("too many words owed: limit %0d", OwedDepth);
          bad++;
        end else begin
          owed_q[owed_wr] = want;
          owed_wr = (owed_wr + 1) % OwedDepth;
          owed_n++;
        end
        words++;
        if (word_kind_i == KindCheck) checks++;
        if (want.discard) discards++;
      end
    end
    mismatches_o <= bad;
    pending_o <= owed_n;
    words_o <= words;
    checks_o <= checks;
    discards_o <= discards;
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the repeat limiter with a short directed sequence and then with
// phases of random check and record words over a small pool of hot keys,
// under a range of window sizes and repeat limits, with random gaps on
// the input side and random back-pressure on the output side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rkrl_pkg::*;

  localparam int unsigned Limit       = 1_000_000;
  localparam int unsigned RandomWords = 1650;
  localparam int unsigned Phases      = 12;
  localparam int unsigned CalmPhase   = 3;
  localparam int unsigned HotMax      = 6;

  // indexes the block must ignore
  localparam logic [CfgIdxW-1:0] RegUnused = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTop    = 8'hff;

  // big windows first so the ring fills, then shrink and vary the limit
  localparam logic [CfgW-1:0] PhaseWin [Phases] =
    '{8'd128, 8'd128, 8'd255, 8'd64, 8'd8, 8'd1, 8'd0, 8'd200, 8'd16, 8'd3, 8'd128, 8'd100};
  localparam logic [CfgW-1:0] PhaseLim [Phases] =
    '{8'd6, 8'd128, 8'd0, 8'd4, 8'd2, 8'd0, 8'd0, 8'd3, 8'd255, 8'd5, 8'd0, 8'd30};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = KindCheck;
  logic [KeyW-1:0]    in_key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_discard;
  logic [CountW-1:0]  out_match_count;

  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        words;
  int unsigned        checks;
  int unsigned        discards;
  int unsigned        cycles = 0;
  logic               calm = 1'b0;
  logic [KeyW-1:0]    hot_keys [HotMax];
  int unsigned        hot_n = 1;
  int unsigned        rec_pct = 50;

  always #5 clk = ~clk;

  recent_key_repeat_limiter dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_kind_i         (in_kind),
    .in_key_i          (in_key),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_discard_o     (out_discard),
    .out_match_count_o (out_match_count)
  );

  rkrl_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .word_valid_i  (in_valid),
    .word_ready_i  (in_ready),
    .word_kind_i   (in_kind),
    .word_key_i    (in_key),
    .res_valid_i   (out_valid),
    .res_ready_i   (out_ready),
    .res_discard_i (out_discard),
    .res_count_i   (out_match_count),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .words_o       (words),
    .checks_o      (checks),
    .discards_o    (discards)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("timed out after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays up into the next word unless a gap is taken
  task automatic send_word(logic kind, logic [KeyW-1:0] key);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data, logic lower);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (lower) cfg_valid <= 1'b0;
  endtask

  // wait for every owed result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    logic [KeyW-1:0] k;
    r = $urandom_range(99);
    k = hot_keys[$urandom_range(hot_n - 1)];
    if (r < 70) return k;
    // near miss: one bit away from a hot key
    if (r < 80) return k ^ (KeyW'(1) << $urandom_range(KeyW - 1));
    if (r < 85) return '0;
    if (r < 90) return '1;
    return $urandom();
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty window, then a few entries with both extreme keys
    send_word(KindCheck, '0);
    send_word(KindRecord, '0);
    send_word(KindRecord, '1);
    send_word(KindRecord, '0);
    send_word(KindCheck, '0);
    send_word(KindCheck, '1);
    send_word(KindCheck, 32'h0000_0001);
    send_word(KindRecord, 32'h8000_0000);
    send_word(KindCheck, 32'h8000_0000);
    drain();
    write_reg(RegDupLimit, 8'd1, 1'b1);
    send_word(KindCheck, '0);
    send_word(KindCheck, '1);
    // window shrunk under the fill, and no longer above the limit
    drain();
    write_reg(RegWindowSize, 8'd1, 1'b1);
    send_word(KindCheck, '0);
    send_word(KindRecord, '1);
    send_word(KindCheck, '1);
    // zero window acts as one but still compares raw against the limit
    drain();
    write_reg(RegWindowSize, 8'd0, 1'b0);
    write_reg(RegDupLimit, 8'd0, 1'b1);
    send_word(KindRecord, 32'h5a5a_5a5a);
    send_word(KindCheck, 32'h5a5a_5a5a);
    // oversize window, and writes to indexes that do not exist
    drain();
    write_reg(RegWindowSize, 8'd255, 1'b0);
    write_reg(RegUnused, 8'hff, 1'b0);
    write_reg(RegTop, 8'h00, 1'b1);
    send_word(KindCheck, '1);
    send_word(KindRecord, '1);
    send_word(KindCheck, '1);

    for (int p = 0; p < Phases; p++) begin
      drain();
      write_reg(RegWindowSize, PhaseWin[p], 1'b0);
      write_reg(RegDupLimit, PhaseLim[p], 1'b1);
      calm <= (p == CalmPhase);
      hot_n = $urandom_range(1, HotMax);
      for (int i = 0; i < HotMax; i++) hot_keys[i] = $urandom();
      rec_pct = $urandom_range(30, 75);
      for (int n = 0; n < RandomWords / Phases; n++) begin
        send_word(($urandom_range(99) < rec_pct) ? KindRecord : KindCheck, pick_key());
      end
    end
    drain();
    calm <= 1'b0;
    repeat (140) @(posedge clk);

    $display("%0d words (%0d checks, %0d flagged for discard) over %0d register settings",
             words, checks, discards, Phases + 5);
    $display("window sizes 0 to 255, repeat limits 0 to 255, gaps and back-pressure");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rkrl_pkg.sv
rtl/rkrl_ctrl.sv
rtl/rkrl_dp.sv
rtl/recent_key_repeat_limiter.sv
bench/rkrl_checker.sv
bench/testbench.sv
